// ----- hdl/plcs_pkg.sv -----
// Shared constants, codes and types of the piecewise linear curve sampler.
`default_nettype none
package plcs_pkg;

	localparam int CURVES_DEF = 8;
	localparam int POINTS_DEF = 16;

	localparam int OP_W    = 2;
	localparam int CSEL_W  = 3;
	localparam int PIDX_W  = 4;
	localparam int PCNT_W  = 5;
	localparam int TRIG_W  = 16;
	localparam int VAL_W   = 32;
	localparam int DIV_STEPS = 32;

	localparam logic signed [TRIG_W-1:0] PCT_FULL = 16'sd25600;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_LEN    = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_SCAN,
		ST_DEC,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/piecewise_linear_curve_sampler_core.sv -----
// Top level of the piecewise linear curve sampler: point store, scan sequencer, divider.
// Point write, length set and unused codes are taken in the idle state; the next request follows at once.
// A sample reads the curve length, scans the n points of the curve and decides the result; an empty
// curve skips the scan, and an interpolation adds a multiply and 32 restoring divide steps.
// One request is in flight at a time; a finished result waits in the output register.
// Reset clears the curve length valid bits and control state; point storage is undefined until written.
`default_nettype none
module piecewise_linear_curve_sampler_core #(
	parameter int CURVES = plcs_pkg::CURVES_DEF,
	parameter int POINTS = plcs_pkg::POINTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [plcs_pkg::OP_W-1:0]            op,
	input  wire logic [plcs_pkg::CSEL_W-1:0]          curve_sel,
	input  wire logic [plcs_pkg::PIDX_W-1:0]          point_index,
	input  wire logic [plcs_pkg::PCNT_W-1:0]          point_count,
	input  wire logic signed [plcs_pkg::TRIG_W-1:0]   point_trigger,
	input  wire logic signed [plcs_pkg::VAL_W-1:0]    point_value,
	input  wire logic signed [plcs_pkg::TRIG_W-1:0]   sample_pct,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [plcs_pkg::VAL_W-1:0]         value_out,
	output logic                                      curve_valid,
	output logic                                      curve_empty
);
	import plcs_pkg::*;

	localparam int CW = (CURVES > 1) ? $clog2(CURVES) : 1;
	localparam int PW = $clog2(POINTS);
	localparam int LW = $clog2(POINTS + 1);
	localparam int AW = CW + PW;
	localparam int DEPTH = 2 ** AW;
	localparam int SW = $clog2(DIV_STEPS);
	localparam int EW = TRIG_W + VAL_W;

	state_t state_q, state_d;

	logic              acc;
	op_t               op_in;
	logic [CW-1:0]     cv_idx;
	logic              cv_ok;
	logic              pt_we;
	logic              len_we;
	logic [LW-1:0]     cnt_sat;
	logic [AW-1:0]     pt_raddr;

	logic [EW-1:0]     pt_mem [DEPTH];
	logic [EW-1:0]     pt_rd_q;
	logic [LW-1:0]     len_mem [CURVES];
	logic [LW-1:0]     len_rd_q;
	logic [CURVES-1:0] len_vld_q;
	logic              len_hit_q;

	logic [CW-1:0]     cur_q;
	logic signed [TRIG_W-1:0] pct_q;
	logic [LW-1:0]     n_q;
	logic [PW-1:0]     pt_q;
	logic              last_pt;

	logic signed [TRIG_W-1:0] cur_t, first_t_q, prev_t_q, ta_q, tb_q;
	logic signed [VAL_W-1:0]  cur_v, first_v_q, prev_v_q, va_q, vb_q;
	logic              found_q, order_ok_q;

	logic signed [TRIG_W:0]   dt_w, den_w;
	logic signed [VAL_W:0]    dv_w;
	logic [VAL_W:0]           mag_w;
	logic [TRIG_W-1:0]        dt_q, den_q;
	logic [VAL_W-1:0]         mag_q;
	logic                     neg_q;
	logic [EW-1:0]            prod_w;

	logic [TRIG_W-1:0]        rem_q;
	logic [VAL_W-1:0]         quo_q;
	logic [TRIG_W:0]          rem_sh;
	logic                     sub_ok;
	logic [SW-1:0]            step_q;

	logic signed [VAL_W-1:0]  res_v_q;
	logic                     res_ok_q, res_empty_q, interp_q;
	logic signed [VAL_W:0]    q_sgn, sum_w;
	logic signed [VAL_W-1:0]  fin_v;
	logic                     out_free;
	logic                     out_load;

	assign op_in    = op_t'(op);
	assign acc      = in_valid && !in_stall;
	assign cv_idx   = CW'(curve_sel);
	assign cv_ok    = int'(curve_sel) < CURVES;
	assign pt_we    = acc && (op_in == OP_WRITE) && cv_ok && (int'(point_index) < POINTS);
	assign len_we   = acc && (op_in == OP_LEN) && cv_ok;
	assign cnt_sat  = (int'(point_count) > POINTS) ? LW'(POINTS) : LW'(point_count);
	assign cur_t    = pt_rd_q[EW-1:VAL_W];
	assign cur_v    = pt_rd_q[VAL_W-1:0];
	assign last_pt  = ({1'b0, pt_q} == (PW+1)'(n_q - LW'(1)));
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[{cv_idx, PW'(point_index)}] <= {point_trigger, point_value};
		end
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[cv_idx] <= cnt_sat;
		end
		len_rd_q <= len_mem[cv_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (len_we) begin
			len_vld_q[cv_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && op_in == OP_SAMPLE) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (len_hit_q && len_rd_q != '0) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCAN: begin
				if (last_pt) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (pct_q > first_t_q && pct_q < prev_t_q && found_q && ta_q != tb_q) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == SW'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		pt_raddr = {cur_q, PW'(pt_q + PW'(1))};
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_LEN:  pt_raddr = {cur_q, PW'(0)};
			ST_FIN:  out_load = out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q     <= cv_idx;
			len_hit_q <= cv_ok && len_vld_q[cv_idx];
			if (sample_pct < 0) begin
				pct_q <= '0;
			end else if (sample_pct > PCT_FULL) begin
				pct_q <= PCT_FULL;
			end else begin
				pct_q <= sample_pct;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LEN: begin
				n_q         <= len_hit_q ? len_rd_q : '0;
				pt_q        <= '0;
				found_q     <= 1'b0;
				order_ok_q  <= 1'b1;
				res_v_q     <= '0;
				res_ok_q    <= 1'b0;
				res_empty_q <= 1'b1;
				interp_q    <= 1'b0;
			end
			ST_SCAN: begin
				if (pt_q == '0) begin
					first_t_q <= cur_t;
					first_v_q <= cur_v;
				end else begin
					if (cur_t < prev_t_q) begin
						order_ok_q <= 1'b0;
					end
					if (!found_q && pct_q >= prev_t_q && pct_q <= cur_t) begin
						found_q <= 1'b1;
						ta_q    <= prev_t_q;
						tb_q    <= cur_t;
						va_q    <= prev_v_q;
						vb_q    <= cur_v;
					end
				end
				prev_t_q <= cur_t;
				prev_v_q <= cur_v;
				pt_q     <= pt_q + PW'(1);
			end
			ST_DEC: begin
				res_empty_q <= 1'b0;
				res_ok_q    <= (n_q > LW'(1)) && (first_t_q == '0) && (prev_t_q == PCT_FULL)
					&& order_ok_q;
				interp_q    <= 1'b0;
				if (pct_q <= first_t_q) begin
					res_v_q <= first_v_q;
				end else if (pct_q >= prev_t_q || !found_q) begin
					res_v_q <= prev_v_q;
				end else if (ta_q == tb_q) begin
					res_v_q <= vb_q;
				end else begin
					interp_q <= 1'b1;
				end
				dt_q  <= dt_w[TRIG_W-1:0];
				den_q <= den_w[TRIG_W-1:0];
				mag_q <= mag_w[VAL_W-1:0];
				neg_q <= dv_w[VAL_W];
			end
			ST_MUL: begin
				rem_q  <= prod_w[EW-1:VAL_W];
				quo_q  <= prod_w[VAL_W-1:0];
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= sub_ok ? TRIG_W'(rem_sh - {1'b0, den_q}) : rem_sh[TRIG_W-1:0];
				quo_q  <= {quo_q[VAL_W-2:0], sub_ok};
				step_q <= step_q + SW'(1);
			end
			default: begin
				pt_q <= pt_q;
			end
		endcase
	end

	assign dt_w   = {pct_q[TRIG_W-1], pct_q} - {ta_q[TRIG_W-1], ta_q};
	assign den_w  = {tb_q[TRIG_W-1], tb_q} - {ta_q[TRIG_W-1], ta_q};
	assign dv_w   = {vb_q[VAL_W-1], vb_q} - {va_q[VAL_W-1], va_q};
	assign mag_w  = dv_w[VAL_W] ? (VAL_W+1)'(-dv_w) : (VAL_W+1)'(dv_w);
	assign prod_w = EW'({{VAL_W{1'b0}}, dt_q} * {{TRIG_W{1'b0}}, mag_q});

	assign rem_sh = {rem_q, quo_q[VAL_W-1]};
	assign sub_ok = rem_sh >= {1'b0, den_q};

	assign q_sgn  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum_w  = {va_q[VAL_W-1], va_q} + q_sgn;
	assign fin_v  = interp_q ? sum_w[VAL_W-1:0] : res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_out   <= fin_v;
			curve_valid <= res_ok_q;
			curve_empty <= res_empty_q;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/plcs_chk.sv -----
// Port-level checker of the curve sampler and its bind to the top level.
`default_nettype none
module plcs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  op,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] value_out,
	input wire logic        curve_valid,
	input wire logic        curve_empty
);
	import plcs_pkg::*;

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out))
		else $error("stalled result changed");

	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_SAMPLE |=> in_stall)
		else $error("sample request not held busy");

	ap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && curve_empty |-> value_out == '0 && !curve_valid)
		else $error("empty curve result malformed");

	ap_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without sample in flight");

endmodule

bind piecewise_linear_curve_sampler_core plcs_chk u_plcs_chk (.*);
`default_nettype wire

// ----- tb/sv/tb_piecewise_linear_curve_sampler_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the curve sampler core: point writes, length sets, samples and unused codes.
module tb_piecewise_linear_curve_sampler_core;
	import plcs_pkg::*;

	localparam int CURVES      = CURVES_DEF;
	localparam int POINTS      = POINTS_DEF;
	localparam int PCT_MAX     = 25600;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 80;
	localparam int PHASE_ITEMS = 235;

	typedef struct {
		op_t                      op;
		logic [CSEL_W-1:0]        curve;
		logic [PIDX_W-1:0]        index;
		logic [PCNT_W-1:0]        count;
		logic signed [TRIG_W-1:0] trig;
		logic signed [VAL_W-1:0]  value;
		logic signed [TRIG_W-1:0] pct;
	} curve_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    valid;
		logic                    empty;
	} sample_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	op_t                      op = OP_WRITE;
	logic [CSEL_W-1:0]        curve_sel = '0;
	logic [PIDX_W-1:0]        point_index = '0;
	logic [PCNT_W-1:0]        point_count = '0;
	logic signed [TRIG_W-1:0] point_trigger = '0;
	logic signed [VAL_W-1:0]  point_value = '0;
	logic signed [TRIG_W-1:0] sample_pct = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [VAL_W-1:0]  value_out;
	logic                     curve_valid;
	logic                     curve_empty;

	// predictor state, updated on accepted requests
	logic signed [TRIG_W-1:0] trig_mem [CURVES*POINTS];
	logic signed [VAL_W-1:0]  val_mem [CURVES*POINTS];
	int                       len_mem [CURVES] = '{default: 0};
	sample_res_t              expected_samples [$];

	// stimulus shadow, updated as requests are queued
	curve_req_t               request_q [$];
	curve_req_t               active_req;
	logic [POINTS-1:0]        gen_written [CURVES] = '{default: '0};
	int                       gen_trig [CURVES][POINTS];
	int                       gen_len [CURVES] = '{default: 0};
	int                       item_cnt = 0;

	int                       send_idle_pct = 0;
	int                       recv_stall_pct = 0;
	int                       mismatch_cnt = 0;
	int                       cycle_cnt = 0;
	sample_res_t              want;

	piecewise_linear_curve_sampler_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.curve_sel     (curve_sel),
		.point_index   (point_index),
		.point_count   (point_count),
		.point_trigger (point_trigger),
		.point_value   (point_value),
		.sample_pct    (sample_pct),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value_out     (value_out),
		.curve_valid   (curve_valid),
		.curve_empty   (curve_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void apply_request(curve_req_t r);
		int          base, n, p, ta, tb, i;
		longint      va, vb, res;
		bit          ok, found;
		sample_res_t s;
		base = int'(r.curve) * POINTS;
		case (r.op)
			OP_WRITE: begin
				trig_mem[base + int'(r.index)] = r.trig;
				val_mem[base + int'(r.index)] = r.value;
			end
			OP_LEN: len_mem[r.curve] = (r.count > POINTS) ? POINTS : int'(r.count);
			OP_SAMPLE: begin
				p = r.pct;
				if (p < 0)
					p = 0;
				if (p > PCT_MAX)
					p = PCT_MAX;
				n = len_mem[r.curve];
				res = 0;
				ok = 1'b0;
				if (n > 0) begin
					if (p <= trig_mem[base]) begin
						res = val_mem[base];
					end else if (p >= trig_mem[base + n - 1]) begin
						res = val_mem[base + n - 1];
					end else begin
						found = 1'b0;
						res = val_mem[base + n - 1];
						for (i = 0; i < n - 1; i++) begin
							ta = trig_mem[base + i];
							tb = trig_mem[base + i + 1];
							if (!found && p >= ta && p <= tb) begin
								found = 1'b1;
								va = val_mem[base + i];
								vb = val_mem[base + i + 1];
								if (ta == tb)
									res = vb;
								else
									res = va + (longint'(p - ta) * (vb - va)) /
										longint'(tb - ta);
							end
						end
					end
					ok = (n >= 2) && (trig_mem[base] == 0) && (trig_mem[base + n - 1] == PCT_MAX);
					for (i = 1; i < n; i++) begin
						if (trig_mem[base + i] < trig_mem[base + i - 1])
							ok = 1'b0;
					end
				end
				s.value = res[VAL_W-1:0];
				s.valid = ok;
				s.empty = (n == 0);
				expected_samples = {expected_samples, s};
			end
			default: ;
		endcase
	endfunction

	function automatic curve_req_t rand_req(op_t o, int c);
		curve_req_t r;
		r.op = o;
		r.curve = c;
		r.index = $urandom;
		r.count = $urandom;
		r.trig = $urandom;
		r.value = $urandom;
		r.pct = $urandom;
		return r;
	endfunction

	task automatic push_req(curve_req_t r);
		request_q = {request_q, r};
		case (r.op)
			OP_WRITE: begin
				gen_written[r.curve][r.index] = 1'b1;
				gen_trig[r.curve][r.index] = r.trig;
			end
			OP_LEN: gen_len[r.curve] = (r.count > POINTS) ? POINTS : int'(r.count);
			default: ;
		endcase
		if (r.op != OP_NONE)
			item_cnt++;
	endtask

	task automatic write_point(int c, int idx, logic signed [TRIG_W-1:0] t,
			logic signed [VAL_W-1:0] v);
		curve_req_t r;
		r = rand_req(OP_WRITE, c);
		r.index = idx;
		r.trig = t;
		r.value = v;
		push_req(r);
	endtask

	task automatic set_length(int c, int cnt);
		curve_req_t r;
		r = rand_req(OP_LEN, c);
		r.count = cnt;
		push_req(r);
	endtask

	task automatic sample_curve(int c, logic signed [TRIG_W-1:0] pct);
		curve_req_t r;
		r = rand_req(OP_SAMPLE, c);
		r.pct = pct;
		push_req(r);
	endtask

	function automatic logic signed [TRIG_W-1:0] pick_pct(int c);
		int k;
		k = $urandom_range(99);
		if (k < 55)
			return $urandom_range(PCT_MAX);
		if (k < 75 && gen_len[c] > 0)
			return gen_trig[c][$urandom_range(gen_len[c] - 1)];
		return $urandom;
	endfunction

	function automatic int written_prefix(int c);
		int k;
		k = 0;
		while (k < POINTS && gen_written[c][k])
			k++;
		return k;
	endfunction

	task automatic build_curve();
		int                      c, n, i, j, tmp, cnt;
		int                      tg [POINTS];
		bit                      sorted;
		logic signed [VAL_W-1:0] v;
		c = $urandom_range(CURVES - 1);
		n = ($urandom_range(3) == 0) ? $urandom_range(9, POINTS) : $urandom_range(1, 8);
		sorted = ($urandom_range(99) < 75);
		for (i = 0; i < n; i++) begin
			if (sorted)
				tg[i] = (i > 0 && $urandom_range(4) == 0) ? tg[i-1] : $urandom_range(PCT_MAX);
			else
				tg[i] = $urandom_range(1) ? $urandom_range(65535) - 32768 : $urandom_range(PCT_MAX);
		end
		if (sorted) begin
			for (i = 1; i < n; i++) begin
				for (j = i; j > 0 && tg[j-1] > tg[j]; j--) begin
					tmp = tg[j];
					tg[j] = tg[j-1];
					tg[j-1] = tmp;
				end
			end
			tg[0] = 0;
			if (n > 1)
				tg[n-1] = ($urandom_range(9) == 0) ? PCT_MAX - 1 : PCT_MAX;
		end
		for (i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7FFF_FFFF;
				default: v = $urandom;
			endcase
			write_point(c, i, tg[i], v);
		end
		cnt = (n == POINTS && $urandom_range(1)) ? $urandom_range(POINTS, 31) : n;
		set_length(c, cnt);
		repeat ($urandom_range(1, 3))
			sample_curve(c, pick_pct(c));
	endtask

	task automatic run_random(int items);
		int stop, c, k, pre;
		stop = item_cnt + items;
		while (item_cnt < stop) begin
			k = $urandom_range(99);
			c = $urandom_range(CURVES - 1);
			if (k < 45) begin
				build_curve();
			end else if (k < 80) begin
				sample_curve(c, pick_pct(c));
			end else if (k < 88) begin
				pre = written_prefix(c);
				set_length(c, (pre == POINTS && $urandom_range(2) == 0) ?
					$urandom_range(POINTS, 31) : $urandom_range(pre));
			end else if (k < 95) begin
				write_point(c, $urandom_range(POINTS - 1), $urandom, $urandom);
			end else begin
				push_req(rand_req(OP_NONE, c));
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				apply_request(active_req);
			if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				active_req = request_q.pop_front();
				op <= active_req.op;
				curve_sel <= active_req.curve;
				point_index <= active_req.index;
				point_count <= active_req.count;
				point_trigger <= active_req.trig;
				point_value <= active_req.value;
				sample_pct <= active_req.pct;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected sample result: value %h valid %b empty %b",
							value_out, curve_valid, curve_empty);
				end else begin
					want = expected_samples.pop_front();
					if (value_out !== want.value || curve_valid !== want.valid ||
							curve_empty !== want.empty) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("sample mismatch: exp %h %b %b, got %h %b %b",
								want.value, want.valid, want.empty,
								value_out, curve_valid, curve_empty);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** piecewise_linear_curve_sampler_core: FAILED **");
			$finish;
		end
	end

	initial begin
		logic signed [TRIG_W-1:0] probe_pct [8];
		int ph;
		probe_pct = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd3200,
			16'sd6400, 16'sd12800, 16'sd19200, 16'sd25600};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty curve
		sample_curve(0, 16'sd0);
		// full-range values, zero-width segment at mid scale
		write_point(1, 0, 16'sd0, 32'sh8000_0000);
		write_point(1, 1, 16'sd6400, 32'sh7FFF_FFFF);
		write_point(1, 2, 16'sd12800, 32'sh1234_5678);
		write_point(1, 3, 16'sd12800, -32'sd5);
		write_point(1, 4, 16'sd25600, 32'sd0);
		set_length(1, 5);
		foreach (probe_pct[i])
			sample_curve(1, probe_pct[i]);
		// single point at the most negative trigger
		write_point(2, 0, 16'sh8000, 32'sh0001_0000);
		set_length(2, 1);
		sample_curve(2, 16'sd100);
		push_req(rand_req(OP_NONE, 5));
		// descending triggers
		write_point(3, 0, 16'sd25600, 32'sd100);
		write_point(3, 1, 16'sd0, -32'sd100);
		set_length(3, 2);
		sample_curve(3, 16'sd12800);
		// shrink back to empty
		set_length(1, 0);
		sample_curve(1, 16'sd12800);
		while (request_q.size() > 0 || in_valid || expected_samples.size() > 0)
			@(negedge clk);

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 76;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 76;
				end
				default: begin
					send_idle_pct = 11;
					recv_stall_pct = 11;
				end
			endcase
			run_random(PHASE_ITEMS);
			// hold until every result has drained
			while (request_q.size() > 0 || in_valid || expected_samples.size() > 0)
				@(negedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("** piecewise_linear_curve_sampler_core: PASSED **");
		else
			$display("** piecewise_linear_curve_sampler_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/plcs_pkg.sv
hdl/piecewise_linear_curve_sampler_core.sv
hdl/plcs_chk.sv
tb/sv/tb_piecewise_linear_curve_sampler_core.sv
